/* src/r4ntt_pkg.sv */
// r4ntt_pkg: types, prime constants and modular helper functions for the
// radix-4 NTT butterfly. No dependencies.
`default_nettype none
package r4ntt_pkg;

  localparam int unsigned ResW   = 31;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned SelW   = 2;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ResW-1:0]  res_t;

  typedef enum logic [ReqW-1:0] {
    ReqFwd   = 2'd0,
    ReqBck   = 2'd1,
    ReqFirst = 2'd2,
    ReqSqr   = 2'd3
  } req_e;

  localparam logic [SelW-1:0] SelP0 = 2'd0;
  localparam logic [SelW-1:0] SelP1 = 2'd1;
  localparam logic [SelW-1:0] SelP2 = 2'd2;

  typedef struct packed {
    word_t p;
    word_t q;
    word_t rsq;
    word_t ri;
    word_t rs;
    word_t ris;
  } prime_t;

  function automatic prime_t prime_consts(logic [SelW-1:0] sel);
    prime_t c;
    unique case (sel)
      SelP0: c = '{32'd2130706433, 32'd2164260865, 32'd402124772,
                   32'd1930170389, 32'd1626730317, 32'd856006302};
      SelP1: c = '{32'd2113929217, 32'd2181038081, 32'd2111798781,
                   32'd1036950657, 32'd338852760, 32'd1090446030};
      default: c = '{32'd2013265921, 32'd2281701377, 32'd1172168163,
                     32'd734725699, 32'd1032137103, 32'd1964242958};
    endcase
    return c;
  endfunction

  function automatic word_t mod_add(word_t a, word_t b, word_t p);
    word_t t;
    t = a + b;
    return (t >= p) ? t - p : t;
  endfunction

  function automatic word_t mod_sub(word_t a, word_t b, word_t p);
    word_t t;
    t = a - b;
    return t[WordW-1] ? t + p : t;
  endfunction

endpackage
`default_nettype wire

/* src/r4ntt_if.sv */
// r4ntt_in_if / r4ntt_out_if: valid/ready channels for butterfly items.
// Depends on r4ntt_pkg.
`default_nettype none
interface r4ntt_in_if import r4ntt_pkg::*; ();
  logic valid;
  logic ready;
  logic [ReqW-1:0] req_type;
  res_t elem_0, elem_1, elem_2, elem_3;
  res_t tw_a, tw_b, tw_c;
  modport source(output valid, req_type, elem_0, elem_1, elem_2, elem_3,
                 tw_a, tw_b, tw_c, input ready);
  modport sink(input valid, req_type, elem_0, elem_1, elem_2, elem_3,
               tw_a, tw_b, tw_c, output ready);
endinterface

interface r4ntt_out_if import r4ntt_pkg::*; ();
  logic valid;
  logic ready;
  res_t out_0, out_1, out_2, out_3;
  modport source(output valid, out_0, out_1, out_2, out_3, input ready);
  modport sink(input valid, out_0, out_1, out_2, out_3, output ready);
endinterface
`default_nettype wire

/* src/r4ntt_mont.sv */
// r4ntt_mont: pipelined Montgomery multiplier, a*b*2^-32 mod p.
// Depends on r4ntt_pkg.
`default_nettype none
module r4ntt_mont import r4ntt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire word_t a_i,
  input  wire word_t b_i,
  input  wire word_t p_i,
  input  wire word_t q_i,
  output word_t      r_o
);
  logic [2*WordW-1:0] t_q;
  logic [2*WordW-1:0] mp_full;
  word_t p1_q, q1_q, p2_q, p3_q;
  word_t hi1_q, hi2_q, m_q, mp_q;

  assign mp_full = {32'd0, m_q} * {32'd0, p2_q};

  // stage 1: full product; stage 2: m = lo*q; stage 3: high half of m*p
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= {32'd0, a_i} * {32'd0, b_i};
      p1_q  <= p_i;
      q1_q  <= q_i;
      hi1_q <= t_q[2*WordW-1:WordW];
      m_q   <= t_q[WordW-1:0] * q1_q;
      p2_q  <= p1_q;
      hi2_q <= hi1_q;
      mp_q  <= mp_full[2*WordW-1:WordW];
      p3_q  <= p2_q;
    end
  end

  assign r_o = mod_sub(hi2_q, mp_q, p3_q);
endmodule
`default_nettype wire

/* src/radix4_ntt_butterfly_montgomery.sv */
// radix4_ntt_butterfly_montgomery: top level, APB prime select and deep
// pipeline. Depends on r4ntt_pkg, r4ntt_if and r4ntt_mont.
//
//  channel  | dir | handshake      | payload
//  in_if    | in  | valid/ready    | req_type, elem_0..3, tw_a..c
//  out_if   | out | valid/ready    | out_0..3
//  apb      | in  | psel/penable   | prime_select at 0x0
//
// One item per cycle while the global enable is high. Each item passes
// through four levels of one operand register plus the pipelined
// Montgomery multiplier, then the output register. Every request type takes
// the same path, so items stay in order.
// All stages advance together on a global enable: they hold when the output
// register is full and not taken; in_if.ready is that enable.
// Valid bits and prime select clear on reset; payload does not.
`default_nettype none
module radix4_ntt_butterfly_montgomery import r4ntt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  r4ntt_in_if.sink       in_if,
  r4ntt_out_if.source    out_if,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [0:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  localparam int unsigned MulLat = 3;           // Montgomery multiplier depth
  localparam int unsigned LevLat = MulLat + 1;  // operand register + multiplier
  localparam int unsigned NLev   = 4;

  // Level schedule (pre = add/sub before the operand register,
  // post = multiplier results placed into the item):
  //  L0  first: e0*rsq, e1*rsq | fwd: pass | sqr: e2*ta, e3*ta
  //      bck: inner pairs a+b, (b-a) times tb / tc
  //  L1  fwd/first: e2, e3 times ta (or ri) | bck: outer pairs, (b-a)*ta
  //      sqr: outer forward add/sub, then 2a*b and b*b for both pairs
  //  L2  fwd/first: outer add/sub, inner times tb/tc (or rs/ris)
  //      sqr: a*a and b^2*ta for both pairs | bck: pass
  //  L3  fwd/first: inner add/sub | bck: pass
  //      sqr: a^2 + b^2 w, a^2 - b^2 w, then backward pairs with tb

  logic [SelW-1:0] sel_q;
  assign pready = 1'b1;
  assign prdata = {30'd0, sel_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= SelP0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      sel_q <= pwdata[SelW-1:0];
    end
  end

  // selector 3 falls into the last prime's constants
  prime_t pc;
  assign pc = prime_consts(sel_q);

  logic en;
  logic out_v_q;
  assign en = !out_v_q || out_if.ready;
  assign in_if.ready = en;

  // item as it travels: four values, two scratch words, twiddles, request
  typedef struct packed {
    req_e  req;
    word_t x0, x1, x2, x3;
    word_t y0, y1;
    word_t ta, tb, tc;
  } lev_t;

  lev_t lv   [NLev+1];
  logic lv_v [NLev+1];

  assign lv[0] = '{req: req_e'(in_if.req_type),
                   x0: {1'b0, in_if.elem_0}, x1: {1'b0, in_if.elem_1},
                   x2: {1'b0, in_if.elem_2}, x3: {1'b0, in_if.elem_3},
                   y0: '0, y1: '0,
                   ta: {1'b0, in_if.tw_a}, tb: {1'b0, in_if.tw_b},
                   tc: {1'b0, in_if.tw_c}};
  assign lv_v[0] = in_if.valid;

  for (genvar l = 0; l < NLev; l++) begin : g_lev
    lev_t  pre, post;
    word_t ma   [4];
    word_t mb   [4];
    word_t ma_q [4];
    word_t mb_q [4];
    word_t mr   [4];
    word_t c0, c2;
    lev_t  dl_q [LevLat];
    logic  dv_q [LevLat];

    always_comb begin
      pre = lv[l];
      c0  = '0;
      c2  = '0;
      for (int k = 0; k < 4; k++) begin
        ma[k] = 32'd1;
        mb[k] = 32'd1;
      end
      unique case (l)
        0: begin
          unique case (lv[l].req)
            ReqFwd: ;
            ReqBck: begin
              pre.x0 = mod_add(lv[l].x0, lv[l].x1, pc.p);
              pre.x1 = mod_sub(lv[l].x1, lv[l].x0, pc.p);
              pre.x2 = mod_add(lv[l].x2, lv[l].x3, pc.p);
              pre.x3 = mod_sub(lv[l].x3, lv[l].x2, pc.p);
              ma[1] = pre.x1; mb[1] = lv[l].tb;
              ma[3] = pre.x3; mb[3] = lv[l].tc;
            end
            ReqFirst: begin
              ma[0] = lv[l].x0; mb[0] = pc.rsq;
              ma[1] = lv[l].x1; mb[1] = pc.rsq;
            end
            ReqSqr: begin
              ma[2] = lv[l].x2; mb[2] = lv[l].ta;
              ma[3] = lv[l].x3; mb[3] = lv[l].ta;
            end
          endcase
        end
        1: begin
          unique case (lv[l].req)
            ReqFwd, ReqFirst: begin
              ma[2] = lv[l].x2;
              mb[2] = (lv[l].req == ReqFirst) ? pc.ri : lv[l].ta;
              ma[3] = lv[l].x3;
              mb[3] = (lv[l].req == ReqFirst) ? pc.ri : lv[l].ta;
            end
            ReqBck: begin
              pre.x0 = mod_add(lv[l].x0, lv[l].x2, pc.p);
              pre.x2 = mod_sub(lv[l].x2, lv[l].x0, pc.p);
              pre.x1 = mod_add(lv[l].x1, lv[l].x3, pc.p);
              pre.x3 = mod_sub(lv[l].x3, lv[l].x1, pc.p);
              ma[2] = pre.x2; mb[2] = lv[l].ta;
              ma[3] = pre.x3; mb[3] = lv[l].ta;
            end
            ReqSqr: begin
              // outer forward pairs; a values stay in x0/x2
              pre.x0 = mod_add(lv[l].x0, lv[l].x2, pc.p);
              pre.x2 = mod_sub(lv[l].x0, lv[l].x2, pc.p);
              pre.x1 = mod_add(lv[l].x1, lv[l].x3, pc.p);
              pre.x3 = mod_sub(lv[l].x1, lv[l].x3, pc.p);
              ma[0] = mod_add(pre.x0, pre.x0, pc.p); mb[0] = pre.x1;
              ma[1] = pre.x1; mb[1] = pre.x1;
              ma[2] = mod_add(pre.x2, pre.x2, pc.p); mb[2] = pre.x3;
              ma[3] = pre.x3; mb[3] = pre.x3;
            end
          endcase
        end
        2: begin
          unique case (lv[l].req)
            ReqFwd, ReqFirst: begin
              pre.x0 = mod_add(lv[l].x0, lv[l].x2, pc.p);
              pre.x2 = mod_sub(lv[l].x0, lv[l].x2, pc.p);
              pre.x1 = mod_add(lv[l].x1, lv[l].x3, pc.p);
              pre.x3 = mod_sub(lv[l].x1, lv[l].x3, pc.p);
              ma[1] = pre.x1;
              mb[1] = (lv[l].req == ReqFirst) ? pc.rs : lv[l].tb;
              ma[3] = pre.x3;
              mb[3] = (lv[l].req == ReqFirst) ? pc.ris : lv[l].tc;
            end
            ReqBck: ;
            ReqSqr: begin
              ma[0] = lv[l].x0; mb[0] = lv[l].x0;   // a0^2
              ma[1] = lv[l].x1; mb[1] = lv[l].ta;   // b0^2 * w
              ma[2] = lv[l].x2; mb[2] = lv[l].x2;   // a2^2
              ma[3] = lv[l].x3; mb[3] = lv[l].ta;   // b2^2 * w
            end
          endcase
        end
        default: begin
          unique case (lv[l].req)
            ReqFwd, ReqFirst: begin
              pre.x0 = mod_add(lv[l].x0, lv[l].x1, pc.p);
              pre.x1 = mod_sub(lv[l].x0, lv[l].x1, pc.p);
              pre.x2 = mod_add(lv[l].x2, lv[l].x3, pc.p);
              pre.x3 = mod_sub(lv[l].x2, lv[l].x3, pc.p);
            end
            ReqBck: ;
            ReqSqr: begin
              // plus w on pair 0, minus w on pair 2; 2ab products in y0/y1
              c0 = mod_add(lv[l].x0, lv[l].x1, pc.p);
              c2 = mod_sub(lv[l].x2, lv[l].x3, pc.p);
              pre.x0 = mod_add(c0, c2, pc.p);
              pre.x2 = mod_sub(c2, c0, pc.p);
              pre.x1 = mod_add(lv[l].y0, lv[l].y1, pc.p);
              pre.x3 = mod_sub(lv[l].y1, lv[l].y0, pc.p);
              ma[2] = pre.x2; mb[2] = lv[l].tb;
              ma[3] = pre.x3; mb[3] = lv[l].tb;
            end
          endcase
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int s = 0; s < LevLat; s++) dv_q[s] <= 1'b0;
      end else if (en) begin
        dv_q[0] <= lv_v[l];
        for (int s = 1; s < LevLat; s++) dv_q[s] <= dv_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_q[0] <= pre;
        for (int s = 1; s < LevLat; s++) dl_q[s] <= dl_q[s-1];
        for (int k = 0; k < 4; k++) begin
          ma_q[k] <= ma[k];
          mb_q[k] <= mb[k];
        end
      end
    end

    for (genvar k = 0; k < 4; k++) begin : g_mul
      r4ntt_mont u_mul (
        .clk_i(clk_i), .en_i(en), .a_i(ma_q[k]), .b_i(mb_q[k]),
        .p_i(pc.p), .q_i(pc.q), .r_o(mr[k])
      );
    end

    // post-op: place multiplier results
    always_comb begin
      post = dl_q[LevLat-1];
      unique case (l)
        0: begin
          unique case (post.req)
            ReqFwd: ;
            ReqBck: begin
              post.x1 = mr[1]; post.x3 = mr[3];
            end
            ReqFirst: begin
              post.x0 = mr[0]; post.x1 = mr[1];
            end
            ReqSqr: begin
              post.x2 = mr[2]; post.x3 = mr[3];
            end
          endcase
        end
        1: begin
          unique case (post.req)
            ReqFwd, ReqFirst, ReqBck: begin
              post.x2 = mr[2]; post.x3 = mr[3];
            end
            ReqSqr: begin
              post.y0 = mr[0]; post.y1 = mr[2];  // 2ab per pair
              post.x1 = mr[1]; post.x3 = mr[3];  // b^2 per pair
            end
          endcase
        end
        2: begin
          unique case (post.req)
            ReqFwd, ReqFirst: begin
              post.x1 = mr[1]; post.x3 = mr[3];
            end
            ReqBck: ;
            ReqSqr: begin
              post.x0 = mr[0]; post.x1 = mr[1];
              post.x2 = mr[2]; post.x3 = mr[3];
            end
          endcase
        end
        default: begin
          if (post.req == ReqSqr) begin
            post.x2 = mr[2]; post.x3 = mr[3];
          end
        end
      endcase
    end

    assign lv[l+1]   = post;
    assign lv_v[l+1] = dv_q[LevLat-1];
  end

  // output register
  res_t o0_q, o1_q, o2_q, o3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= lv_v[NLev];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      o0_q <= lv[NLev].x0[ResW-1:0];
      o1_q <= lv[NLev].x1[ResW-1:0];
      o2_q <= lv[NLev].x2[ResW-1:0];
      o3_q <= lv[NLev].x3[ResW-1:0];
    end
  end
  assign out_if.valid = out_v_q;
  assign out_if.out_0 = o0_q;
  assign out_if.out_1 = o1_q;
  assign out_if.out_2 = o2_q;
  assign out_if.out_3 = o3_q;
endmodule
`default_nettype wire
